// File: rtl/crcc_pkg.sv
// ---------------------------------------------------------------------------
// Cayley graph four-clique check: shared package
// Group sizes, verdict codes and the C7 x S3 arithmetic used to form one
// adjacency row of the Cayley graph.
// ---------------------------------------------------------------------------
package crcc_pkg;

  localparam int GROUP_ORDER = 42;
  localparam int S3_ORDER    = 6;
  localparam int CYC_ORDER   = 7;
  localparam int IDX_W       = 6;
  localparam int IN_W        = GROUP_ORDER - 1;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_SET   = 2'd1;
  localparam logic [1:0] VERDICT_COMPL = 2'd2;

  localparam logic [1:0] PERM3 [S3_ORDER][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}
  };

  localparam logic [2:0] S3_INV [S3_ORDER] = '{
    3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd5
  };

  // Product a*b in S3, b applied first.
  function automatic logic [2:0] s3_mul(input logic [2:0] a, input logic [2:0] b);
    logic [1:0] q [3];
    logic [2:0] res;
    res = 3'd0;
    for (int i = 0; i < 3; i++) begin
      q[i] = 2'd0;
    end
    if (a < 3'(S3_ORDER) && b < 3'(S3_ORDER)) begin
      for (int i = 0; i < 3; i++) begin
        q[i] = PERM3[a][PERM3[b][i]];
      end
      for (int c = 0; c < S3_ORDER; c++) begin
        if (q[0] == PERM3[c][0] && q[1] == PERM3[c][1] && q[2] == PERM3[c][2]) begin
          res = 3'(c);
        end
      end
    end
    return res;
  endfunction

  // Cyclic part of a packed element, for values below the group order.
  function automatic logic [2:0] elem_z(input logic [IDX_W-1:0] g);
    logic [2:0] zz;
    zz = 3'd0;
    for (int z = 1; z < CYC_ORDER; z++) begin
      if (g >= IDX_W'(S3_ORDER * z)) begin
        zz = 3'(z);
      end
    end
    return zz;
  endfunction

  // Row g of the adjacency: bit h is set for h > g when both h and
  // inv(g)*h are members.
  function automatic logic [GROUP_ORDER-1:0] grp_row(input logic [GROUP_ORDER-1:0] members,
                                                     input logic [IDX_W-1:0] g);
    logic [2:0]             zg;
    logic [2:0]             sg;
    logic [2:0]             zi;
    logic [2:0]             si;
    logic [3:0]             zsum;
    logic [2:0]             zp;
    logic [2:0]             sp;
    logic [IDX_W-1:0]       p;
    logic [IDX_W-1:0]       zoff;
    logic [GROUP_ORDER-1:0] row;
    zg   = elem_z(g);
    zoff = IDX_W'({zg, 2'b00}) + IDX_W'({zg, 1'b0});
    sg   = 3'(g - zoff);
    zi   = (zg == 3'd0) ? 3'd0 : 3'(CYC_ORDER) - zg;
    si   = (sg < 3'(S3_ORDER)) ? S3_INV[sg] : 3'd0;
    row  = '0;
    for (int h = 0; h < GROUP_ORDER; h++) begin
      zsum = {1'b0, zi} + 4'(h / S3_ORDER);
      zp   = (zsum >= 4'(CYC_ORDER)) ? 3'(zsum - 4'(CYC_ORDER)) : zsum[2:0];
      sp   = s3_mul(si, 3'(h % S3_ORDER));
      p    = IDX_W'({zp, 2'b00}) + IDX_W'({zp, 1'b0}) + IDX_W'(sp);
      if (IDX_W'(h) > g) begin
        row[h] = members[h] & members[p];
      end
    end
    return row;
  endfunction

endpackage

// File: rtl/cayley_ramsey_clique_check_top.sv
// ---------------------------------------------------------------------------
// Cayley graph four-clique check
// Searches the Cayley graph of C7 x S3 for four pairwise adjacent members,
// first in the connection set and then in its complement.
// ---------------------------------------------------------------------------
// The search is a depth-first scan that visits one candidate element per cycle
// through a single shared adjacency-row unit. One beat is taken at a time; busy
// is high from acceptance until the verdict strobe, and the next beat can be
// taken in the strobe cycle. The receiver cannot stall done_o.
// Reset returns the sequencer to idle; no clearing pass is needed.
module cayley_ramsey_clique_check_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [crcc_pkg::IN_W-1:0] connection_set_i,
  output logic                   done_o,
  output logic [1:0]             verdict_o
);
  import crcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_SIDE_END
  } state_e;

  localparam logic [IDX_W-1:0]       IDX_END = IDX_W'(GROUP_ORDER);
  localparam logic [GROUP_ORDER-1:0] SPAN    = {{(GROUP_ORDER-1){1'b1}}, 1'b0};

  state_e                 state_q;
  logic                   side_q;
  logic [GROUP_ORDER-1:0] set_q;
  logic [GROUP_ORDER-1:0] c1_q;
  logic [GROUP_ORDER-1:0] c2_q;
  logic [IDX_W-1:0]       a_q;
  logic [IDX_W-1:0]       b_q;
  logic [IDX_W-1:0]       c_q;
  logic                   done_q;
  logic [1:0]             verdict_q;

  logic [IDX_W-1:0]       row_g;
  logic [GROUP_ORDER-1:0] row;

  always_comb begin
    unique case (state_q)
      ST_SCAN_A: row_g = a_q;
      ST_SCAN_B: row_g = b_q;
      default:   row_g = c_q;
    endcase
    row = grp_row(set_q, row_g);
  end

  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign verdict_o = verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      side_q    <= 1'b0;
      done_q    <= 1'b0;
      verdict_q <= VERDICT_NONE;
      set_q     <= '0;
      c1_q      <= '0;
      c2_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      c_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            set_q   <= {connection_set_i, 1'b0};
            side_q  <= 1'b0;
            a_q     <= IDX_W'(1);
            state_q <= ST_SCAN_A;
          end
        end
        ST_SCAN_A: begin
          if (a_q == IDX_END) begin
            state_q <= ST_SIDE_END;
          end else begin
            a_q <= a_q + IDX_W'(1);
            if (set_q[a_q]) begin
              c1_q    <= row;
              b_q     <= a_q + IDX_W'(1);
              state_q <= ST_SCAN_B;
            end
          end
        end
        ST_SCAN_B: begin
          if (b_q == IDX_END) begin
            state_q <= ST_SCAN_A;
          end else begin
            b_q <= b_q + IDX_W'(1);
            if (c1_q[b_q]) begin
              c2_q    <= c1_q & row;
              c_q     <= b_q + IDX_W'(1);
              state_q <= ST_SCAN_C;
            end
          end
        end
        ST_SCAN_C: begin
          if (c_q == IDX_END) begin
            state_q <= ST_SCAN_B;
          end else begin
            c_q <= c_q + IDX_W'(1);
            if (c2_q[c_q] && ((c2_q & row) != '0)) begin
              done_q    <= 1'b1;
              verdict_q <= side_q ? VERDICT_COMPL : VERDICT_SET;
              state_q   <= ST_IDLE;
            end
          end
        end
        ST_SIDE_END: begin
          if (!side_q) begin
            set_q   <= SPAN & ~set_q;
            side_q  <= 1'b1;
            a_q     <= IDX_W'(1);
            state_q <= ST_SCAN_A;
          end else begin
            done_q    <= 1'b1;
            verdict_q <= VERDICT_NONE;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/crcc_verdict_checker.sv
// ---------------------------------------------------------------------------
// Cayley graph four-clique check: verdict checker
// Watches the command and verdict ports of the block. Every accepted
// connection set is searched for four pairwise adjacent members, first in the
// set and then in its complement. The expected verdict is queued, and each
// verdict strobe is compared with the oldest queued one.
// ---------------------------------------------------------------------------
module crcc_verdict_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [crcc_pkg::IN_W-1:0] connection_set_i,
  input  logic                      done_i,
  input  logic [1:0]                verdict_i,
  output int                        mismatches_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = crcc_pkg::GROUP_ORDER;

  localparam logic [1:0] S3_PERM [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}
  };

  logic [1:0] expected_verdicts [$];
  int         error_count = 0;

  assign mismatches_o = error_count;

  // Composition in S3 with the right operand applied first.
  function automatic int perm_compose(input int a, input int b);
    int found;
    found = 0;
    for (int c = 0; c < 6; c++) begin
      if (S3_PERM[c][0] == S3_PERM[a][S3_PERM[b][0]] &&
          S3_PERM[c][1] == S3_PERM[a][S3_PERM[b][1]] &&
          S3_PERM[c][2] == S3_PERM[a][S3_PERM[b][2]]) begin
        found = c;
      end
    end
    return found;
  endfunction

  function automatic int element_product(input int a, input int b);
    return 6 * (((a / 6) + (b / 6)) % 7) + perm_compose(a % 6, b % 6);
  endfunction

  function automatic int element_inverse(input int a);
    int s_inv;
    s_inv = 0;
    for (int b = 5; b >= 0; b--) begin
      if (perm_compose(a % 6, b) == 0) begin
        s_inv = b;
      end
    end
    return 6 * ((7 - (a / 6)) % 7) + s_inv;
  endfunction

  function automatic bit holds_four_clique(input logic [NODES-1:0] members);
    logic [NODES-1:0] nbr [NODES];
    logic [NODES-1:0] row;
    logic [NODES-1:0] common_ab;
    logic [NODES-1:0] common_abc;
    int               g_inv;
    bit               hit;
    hit = 1'b0;
    for (int g = 0; g < NODES; g++) begin
      row   = '0;
      g_inv = element_inverse(g);
      for (int h = g + 1; h < NODES; h++) begin
        if (members[element_product(g_inv, h)]) begin
          row[h] = 1'b1;
        end
      end
      nbr[g] = row & members;
    end
    for (int a = 1; a < NODES && !hit; a++) begin
      if (members[a]) begin
        for (int b = a + 1; b < NODES && !hit; b++) begin
          if (nbr[a][b]) begin
            common_ab = nbr[a] & nbr[b];
            for (int c = b + 1; c < NODES && !hit; c++) begin
              if (common_ab[c]) begin
                common_abc = common_ab & nbr[c];
                if (common_abc != '0) begin
                  hit = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    return hit;
  endfunction

  function automatic logic [1:0] predict_verdict(input logic [crcc_pkg::IN_W-1:0] cset);
    logic [NODES-1:0] members;
    logic [NODES-1:0] others;
    logic [1:0]       v;
    members    = {cset, 1'b0};
    others     = ~members;
    others[0]  = 1'b0;
    if (holds_four_clique(members)) begin
      v = crcc_pkg::VERDICT_SET;
    end else if (holds_four_clique(others)) begin
      v = crcc_pkg::VERDICT_COMPL;
    end else begin
      v = crcc_pkg::VERDICT_NONE;
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    logic [1:0] want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_verdicts.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: verdict %0d strobed with no beat outstanding", $realtime, verdict_i);
          end
          error_count = error_count + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_i !== want) begin
            if (error_count < 10) begin
              $display("%0t: verdict mismatch, expected %0d, got %0d", $realtime, want,
                       verdict_i);
            end
            error_count = error_count + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_verdicts.push_back(predict_verdict(connection_set_i));
      end
    end
    pending_o <= expected_verdicts.size();
  end

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// Cayley graph four-clique check: testbench top
// Drives directed connection sets (empty, full, single elements, cosets,
// inverse-closed and one-sided sets) and then random sets of varied density,
// with random sender pauses. The checker predicts and compares each verdict;
// this module gives the final verdict of the run.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W       = crcc_pkg::IN_W;
  localparam int RANDOM_SETS = 122;
  localparam int STALL_LIMIT = 100000;

  localparam int S3_INV_IDX [6] = '{0, 2, 1, 3, 4, 5};

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [IN_W-1:0] connection_set_i;
  logic            done_o;
  logic [1:0]      verdict_o;
  int              mismatches;
  int              pending;
  int              stall_cycles;

  cayley_ramsey_clique_check_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .connection_set_i (connection_set_i),
    .done_o           (done_o),
    .verdict_o        (verdict_o)
  );

  crcc_verdict_checker u_verdict_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .connection_set_i (connection_set_i),
    .done_i           (done_o),
    .verdict_i        (verdict_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] random_mask();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[IN_W-1:0];
  endfunction

  // Adds the inverse of every member, so that adjacency becomes symmetric.
  function automatic logic [IN_W-1:0] close_under_inverse(input logic [IN_W-1:0] mask);
    logic [IN_W-1:0] closed;
    int              j;
    closed = mask;
    for (int k = 1; k <= IN_W; k++) begin
      if (mask[k-1]) begin
        j = 6 * ((7 - k / 6) % 7) + S3_INV_IDX[k % 6];
        closed[j-1] = 1'b1;
      end
    end
    return closed;
  endfunction

  function automatic logic [IN_W-1:0] coset_mask(input int s);
    logic [IN_W-1:0] mask;
    mask = '0;
    for (int k = 1; k <= IN_W; k++) begin
      if (k % 6 == s) begin
        mask[k-1] = 1'b1;
      end
    end
    return mask;
  endfunction

  function automatic logic [IN_W-1:0] few_members();
    logic [IN_W-1:0] mask;
    int              n;
    mask = '0;
    n    = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      mask[$urandom_range(0, IN_W - 1)] = 1'b1;
    end
    return mask;
  endfunction

  task automatic send_set(input logic [IN_W-1:0] mask);
    start            <= 1'b1;
    connection_set_i <= mask;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_verdicts();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    case ($urandom_range(0, 7))
      0: drain_verdicts();
      1, 2: begin
        start <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [IN_W-1:0] mask;
    rst_ni           = 1'b0;
    start            = 1'b0;
    connection_set_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_set('0);
    send_set('1);
    send_set(IN_W'(1));
    send_set(IN_W'(1) << (IN_W - 1));
    sender_gap();
    send_set(~IN_W'(1));
    send_set(~(IN_W'(1) << (IN_W - 1)));
    send_set(IN_W'({21{2'b01}}));
    send_set(IN_W'({21{2'b10}}));
    send_set(IN_W'(5'h1f));
    send_set(~IN_W'(5'h1f));
    sender_gap();
    send_set(IN_W'({20{1'b1}}));
    send_set(~IN_W'({20{1'b1}}));
    send_set(coset_mask(1));
    send_set(coset_mask(3));
    send_set(coset_mask(1) | coset_mask(2));
    send_set(coset_mask(0) | coset_mask(3) | coset_mask(4));
    send_set(close_under_inverse(few_members()));
    send_set(few_members());
    drain_verdicts();

    for (int i = 0; i < RANDOM_SETS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mask = random_mask();
        4, 5:       mask = close_under_inverse(random_mask() & random_mask());
        6:          mask = random_mask() & random_mask() & random_mask();
        7:          mask = random_mask() | random_mask() | random_mask();
        8:          mask = close_under_inverse(random_mask() & random_mask() &
                                               random_mask());
        default:    mask = few_members();
      endcase
      send_set(mask);
      if (i == RANDOM_SETS / 2) begin
        drain_verdicts();
      end else if (i < RANDOM_SETS - 20) begin
        sender_gap();
      end
    end

    drain_verdicts();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/crcc_pkg.sv
rtl/cayley_ramsey_clique_check_top.sv
verif/crcc_verdict_checker.sv
verif/tb.sv
